### rtl/mlp_backprop_train_step_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the perceptron training block
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef MLP_BACKPROP_TRAIN_STEP_DEFINES_SVH
`define MLP_BACKPROP_TRAIN_STEP_DEFINES_SVH

// same-cycle implication
`define MLPBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MLPBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mlpbp_pkg.sv
// ----------------------------------------------------------------------------
// mlpbp_pkg
// Shared types, default sizes and the logistic lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpbp_pkg;

    localparam int DEF_INPUT_BITS   = 32;
    localparam int DEF_HIDDEN_UNITS = 4;
    localparam int DEF_WEIGHT_BITS  = 24;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;

    localparam logic [31:0] EXP_STEP = 32'd4034748382;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_TRAIN = 2'd2,
        KIND_INFER = 2'd3
    } kind_t;

    typedef logic [15:0] sig_table_t [256];

    // sigmoid(k/16) for k = -128..127, built from a fixed-point exp recurrence
    function automatic sig_table_t build_sig_table();
        sig_table_t  tbl;
        logic [15:0] pos [129];
        logic [95:0] p;
        logic [95:0] den;
        logic [95:0] num;
        logic [95:0] q;
        logic [95:0] r;
        p = 96'd1 << 32;
        for (int k = 0; k <= 128; k++) begin
            den = (96'd1 << 32) + p;
            num = (96'd1 << 48) + (den >> 1);
            q   = '0;
            r   = '0;
            // restoring divide, one quotient bit a step
            for (int b = 63; b >= 0; b--) begin
                r = {r[94:0], num[b]};
                if (r >= den) begin
                    r    = r - den;
                    q[b] = 1'b1;
                end
            end
            pos[k] = q[15:0];
            p = ((p * 96'(EXP_STEP)) + (96'd1 << 31)) >> 32;
        end
        for (int k = 0; k < 256; k++) begin
            if (k >= 128) begin
                tbl[k] = pos[k - 128];
            end else begin
                tbl[k] = 16'(17'h10000 - {1'b0, pos[128 - k]});
            end
        end
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

### rtl/mlpbp_ram.sv
// ----------------------------------------------------------------------------
// mlpbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpbp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 148
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/mlpbp_mul.sv
// ----------------------------------------------------------------------------
// mlpbp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpbp_mul #(
    parameter int A_W = 36,
    parameter int B_W = 26
) (
    input  wire logic                        aclk,
    input  wire logic signed [A_W-1:0]       a,
    input  wire logic signed [B_W-1:0]       b,
    output logic      signed [A_W+B_W-1:0]   prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= (A_W + B_W)'(a) * (A_W + B_W)'(b);
    end

endmodule

`default_nettype wire

### rtl/mlp_backprop_train_step.sv
// One item in flight; all weights sit in one RAM and every product comes from one multiplier.
// Reset (aresetn low, synchronous) clears control state and marks all weights zero.
// ----------------------------------------------------------------------------
// mlp_backprop_train_step
// Fixed-point perceptron: weight load/read, inference and one backprop step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mlp_backprop_train_step_defines.svh"

module mlp_backprop_train_step #(
    parameter int INPUT_BITS   = mlpbp_pkg::DEF_INPUT_BITS,
    parameter int HIDDEN_UNITS = mlpbp_pkg::DEF_HIDDEN_UNITS,
    parameter int WEIGHT_BITS  = mlpbp_pkg::DEF_WEIGHT_BITS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [31:0] sample_bits, [32] target, [40:33] weight_index, [64:41] weight_value
    input  wire logic [mlpbp_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  wire logic [mlpbp_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [15:0] prediction, [33:16] output_error, [57:34] weight_out
    output logic [mlpbp_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int H    = HIDDEN_UNITS;
    localparam int WB   = WEIGHT_BITS;
    localparam int NI   = (INPUT_BITS < 32) ? INPUT_BITS : 32;
    localparam int N0   = INPUT_BITS * H;
    localparam int N1   = H * H;
    localparam int NW   = N0 + N1 + H;
    localparam int AW   = $clog2(NW);
    localparam int CMAX = (NI > H) ? NI : H;
    localparam int CW   = (CMAX > 1) ? $clog2(CMAX) : 1;
    localparam int HW   = (H > 1) ? $clog2(H) : 1;
    localparam int MA   = 2 * WB - 12;
    localparam int MB   = WB + 2;
    localparam int PW   = MA + MB;
    localparam int AC   = PW + 4;

    localparam logic signed [PW-1:0] W_MAX = {{(PW-WB+1){1'b0}}, {(WB-1){1'b1}}};
    localparam logic signed [PW-1:0] W_MIN = ~W_MAX;
    localparam logic signed [PW-1:0] O_MAX = {{(PW-23){1'b0}}, {23{1'b1}}};
    localparam logic signed [PW-1:0] O_MIN = ~O_MAX;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_WAIT, ST_F1, ST_F2, ST_F3, ST_ERR,
        ST_D2, ST_D1, ST_U2, ST_U1, ST_U0, ST_FIN
    } state_t;

    state_t                 state_reg;
    logic [2:0]             st_reg;
    logic [CW-1:0]          i_reg;
    logic [CW-1:0]          j_reg;
    mlpbp_pkg::kind_t       kind_reg;
    logic [31:0]            samp_reg;
    logic                   tgt_reg;
    logic                   idx_ok_reg;
    logic signed [AC-1:0]   acc_reg;
    logic [15:0]            l1_reg [H];
    logic [15:0]            l2_reg [H];
    logic signed [WB-1:0]   d2_reg [H];
    logic signed [MA-1:0]   d1_reg [H];
    logic signed [15:0]     d3_reg;
    logic [14:0]            dtmp_reg;
    logic [15:0]            pred_reg;
    logic signed [17:0]     err_reg;
    logic signed [23:0]     wout_reg;
    logic [NW-1:0]          vld_reg;
    logic                   rvld_reg;
    logic                   m_tvalid_reg;
    logic [15:0]            m_pred_reg;
    logic signed [17:0]     m_err_reg;
    logic signed [23:0]     m_wout_reg;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WB-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [WB-1:0]          ram_rdata;
    logic signed [MA-1:0]   mul_a;
    logic signed [MB-1:0]   mul_b;
    logic signed [PW-1:0]   prod;

    logic                   s_acc;
    mlpbp_pkg::kind_t       s_kind;
    logic [7:0]             s_idx;
    logic signed [23:0]     s_wv;
    logic                   s_idx_ok;
    logic [HW-1:0]          i_h;
    logic [HW-1:0]          j_h;
    logic [AW-1:0]          addr0;
    logic [AW-1:0]          addr1;
    logic [AW-1:0]          addr2;
    logic                   bit_set;
    logic signed [WB-1:0]   w_ext;
    logic signed [PW-1:0]   prod_sh;
    logic [14:0]            dnow;
    logic signed [AC-1:0]   sum_w;
    logic signed [AC-1:0]   sum_p;
    logic                   i_last_in;
    logic                   i_last_h;
    logic                   j_last;
    logic [15:0]            l3_new;

    function automatic logic [15:0] sig_of(input logic signed [AC-1:0] q);
        logic signed [AC-1:0] k;
        logic [7:0]           idx;
        k = q >>> 12;
        if (k < -128) begin
            idx = 8'd0;
        end else if (k > 127) begin
            idx = 8'd255;
        end else begin
            idx = 8'(k + 128);
        end
        return mlpbp_pkg::SIG_TABLE[idx];
    endfunction

    function automatic logic signed [MB-1:0] compl(input logic [15:0] a);
        return MB'(17'h10000 - {1'b0, a});
    endfunction

    function automatic logic signed [WB-1:0] sat_w(input logic signed [PW-1:0] v);
        if (v > W_MAX) begin
            return WB'(W_MAX);
        end else if (v < W_MIN) begin
            return WB'(W_MIN);
        end
        return WB'(v);
    endfunction

    function automatic logic signed [23:0] sat_o(input logic signed [PW-1:0] v);
        if (v > O_MAX) begin
            return 24'(O_MAX);
        end else if (v < O_MIN) begin
            return 24'(O_MIN);
        end
        return 24'(v);
    endfunction

    mlpbp_ram #(
        .WIDTH (WB),
        .DEPTH (NW)
    ) u_wram (
        .aclk      (aclk),
        .we        (ram_we),
        .waddr     (ram_waddr),
        .wdata     (ram_wdata),
        .raddr     (ram_raddr),
        .rdata_reg (ram_rdata)
    );

    mlpbp_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .aclk     (aclk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign s_kind   = mlpbp_pkg::kind_t'(s_tuser[1:0]);
    assign s_idx    = s_tdata[40:33];
    assign s_wv     = s_tdata[64:41];
    assign s_idx_ok = int'(s_idx) < NW;

    assign i_h       = i_reg[HW-1:0];
    assign j_h       = j_reg[HW-1:0];
    assign addr0     = AW'(int'(i_reg) * H + int'(j_reg));
    assign addr1     = AW'(N0 + int'(i_reg) * H + int'(j_reg));
    assign addr2     = AW'(N0 + N1 + int'(j_reg));
    assign bit_set   = samp_reg[5'(i_reg)];
    assign w_ext     = rvld_reg ? $signed(ram_rdata) : '0;
    assign prod_sh   = prod >>> 16;
    assign dnow      = 15'(prod_sh);
    assign sum_w     = acc_reg + AC'(w_ext);
    assign sum_p     = acc_reg + AC'(prod);
    assign i_last_in = (i_reg == CW'(NI - 1));
    assign i_last_h  = (i_reg == CW'(H - 1));
    assign j_last    = (j_reg == CW'(H - 1));
    assign l3_new    = sig_of(sum_p >>> 16);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_wout_reg, m_err_reg, m_pred_reg};

    // RAM ports and multiplier operands per step
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr0;
        ram_wdata = '0;
        ram_raddr = addr0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                ram_raddr = AW'(s_idx);
                ram_waddr = AW'(s_idx);
                ram_wdata = sat_w(PW'(s_wv));
                ram_we    = s_acc && (s_kind == mlpbp_pkg::KIND_LOAD) && s_idx_ok;
            end
            ST_F1: begin
                ram_raddr = addr0;
            end
            ST_F2: begin
                ram_raddr = addr1;
                mul_a     = MA'(w_ext);
                mul_b     = MB'(l1_reg[i_h]);
            end
            ST_F3: begin
                ram_raddr = addr2;
                mul_a     = MA'(w_ext);
                mul_b     = MB'(l2_reg[j_h]);
            end
            ST_ERR: begin
                if (st_reg == 3'd0) begin
                    mul_a = MA'(pred_reg);
                    mul_b = compl(pred_reg);
                end else begin
                    mul_a = MA'(err_reg);
                    mul_b = MB'(dnow);
                end
            end
            ST_D2: begin
                ram_raddr = addr2;
                if (st_reg == 3'd0) begin
                    mul_a = MA'(l2_reg[j_h]);
                    mul_b = compl(l2_reg[j_h]);
                end else if (st_reg == 3'd1) begin
                    mul_a = MA'(w_ext);
                    mul_b = MB'(d3_reg);
                end else begin
                    mul_a = MA'(prod_sh);
                    mul_b = MB'(dtmp_reg);
                end
            end
            ST_D1: begin
                ram_raddr = addr1;
                if (st_reg == 3'd3) begin
                    mul_a = MA'(l1_reg[i_h]);
                    mul_b = compl(l1_reg[i_h]);
                end else if (st_reg == 3'd4) begin
                    mul_a = MA'(acc_reg >>> 16);
                    mul_b = MB'(dnow);
                end else begin
                    mul_a = MA'(w_ext);
                    mul_b = MB'(d2_reg[j_h]);
                end
            end
            ST_U2: begin
                ram_raddr = addr2;
                ram_waddr = addr2;
                mul_a     = MA'(d3_reg);
                mul_b     = MB'(l2_reg[j_h]);
                ram_wdata = sat_w(PW'(w_ext) + prod_sh);
                ram_we    = (st_reg == 3'd1);
            end
            ST_U1: begin
                ram_raddr = addr1;
                ram_waddr = addr1;
                mul_a     = MA'(d2_reg[j_h]);
                mul_b     = MB'(l1_reg[i_h]);
                ram_wdata = sat_w(PW'(w_ext) + prod_sh);
                ram_we    = (st_reg == 3'd1);
            end
            ST_U0: begin
                ram_raddr = addr0;
                ram_waddr = addr0;
                ram_wdata = sat_w(PW'(w_ext) + PW'(d1_reg[j_h]));
                ram_we    = (st_reg == 3'd1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            st_reg       <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rvld_reg <= vld_reg[ram_raddr];
            if (ram_we) begin
                vld_reg[ram_waddr] <= 1'b1;
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        kind_reg   <= s_kind;
                        samp_reg   <= s_tdata[31:0];
                        tgt_reg    <= s_tdata[32];
                        idx_ok_reg <= s_idx_ok;
                        pred_reg   <= '0;
                        err_reg    <= '0;
                        wout_reg   <= '0;
                        acc_reg    <= '0;
                        i_reg      <= '0;
                        j_reg      <= '0;
                        st_reg     <= '0;
                        unique case (s_kind)
                            mlpbp_pkg::KIND_LOAD:  state_reg <= ST_FIN;
                            mlpbp_pkg::KIND_READ:  state_reg <= ST_RD_WAIT;
                            mlpbp_pkg::KIND_TRAIN,
                            mlpbp_pkg::KIND_INFER: state_reg <= ST_F1;
                            default:               state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_RD_WAIT: begin
                    wout_reg  <= idx_ok_reg ? sat_o(PW'(w_ext)) : '0;
                    state_reg <= ST_FIN;
                end
                ST_F1: begin
                    if (st_reg == 3'd0 && bit_set) begin
                        st_reg <= 3'd1;
                    end else begin
                        // skip a clear input or fold in the fetched weight
                        st_reg <= 3'd0;
                        if (i_last_in) begin
                            l1_reg[j_h] <= sig_of((st_reg == 3'd1) ? sum_w : acc_reg);
                            acc_reg     <= '0;
                            i_reg       <= '0;
                            if (j_last) begin
                                j_reg     <= '0;
                                state_reg <= ST_F2;
                            end else begin
                                j_reg <= j_reg + 1'b1;
                            end
                        end else begin
                            acc_reg <= (st_reg == 3'd1) ? sum_w : acc_reg;
                            i_reg   <= i_reg + 1'b1;
                        end
                    end
                end
                ST_F2: begin
                    if (st_reg != 3'd2) begin
                        st_reg <= st_reg + 3'd1;
                    end else begin
                        st_reg <= 3'd0;
                        if (i_last_h) begin
                            l2_reg[j_h] <= sig_of(sum_p >>> 16);
                            acc_reg     <= '0;
                            i_reg       <= '0;
                            if (j_last) begin
                                j_reg     <= '0;
                                state_reg <= ST_F3;
                            end else begin
                                j_reg <= j_reg + 1'b1;
                            end
                        end else begin
                            acc_reg <= sum_p;
                            i_reg   <= i_reg + 1'b1;
                        end
                    end
                end
                ST_F3: begin
                    if (st_reg != 3'd2) begin
                        st_reg <= st_reg + 3'd1;
                    end else begin
                        st_reg <= 3'd0;
                        if (j_last) begin
                            acc_reg  <= '0;
                            j_reg    <= '0;
                            pred_reg <= l3_new;
                            if (kind_reg == mlpbp_pkg::KIND_TRAIN) begin
                                err_reg   <= (tgt_reg ? 18'sh10000 : 18'sh0)
                                             - $signed({2'b0, l3_new});
                                state_reg <= ST_ERR;
                            end else begin
                                state_reg <= ST_FIN;
                            end
                        end else begin
                            acc_reg <= sum_p;
                            j_reg   <= j_reg + 1'b1;
                        end
                    end
                end
                ST_ERR: begin
                    if (st_reg != 3'd2) begin
                        st_reg <= st_reg + 3'd1;
                    end else begin
                        d3_reg    <= 16'(prod_sh);
                        st_reg    <= 3'd0;
                        state_reg <= ST_D2;
                    end
                end
                ST_D2: begin
                    if (st_reg == 3'd1) begin
                        dtmp_reg <= dnow;
                    end
                    if (st_reg != 3'd3) begin
                        st_reg <= st_reg + 3'd1;
                    end else begin
                        d2_reg[j_h] <= WB'(prod_sh);
                        st_reg      <= 3'd0;
                        if (j_last) begin
                            j_reg     <= '0;
                            i_reg     <= '0;
                            state_reg <= ST_D1;
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                ST_D1: begin
                    unique case (st_reg)
                        3'd0, 3'd1, 3'd3, 3'd4: st_reg <= st_reg + 3'd1;
                        3'd2: begin
                            acc_reg <= sum_p;
                            if (j_last) begin
                                j_reg  <= '0;
                                st_reg <= 3'd3;
                            end else begin
                                j_reg  <= j_reg + 1'b1;
                                st_reg <= 3'd0;
                            end
                        end
                        default: begin
                            d1_reg[i_h] <= MA'(prod_sh);
                            acc_reg     <= '0;
                            st_reg      <= 3'd0;
                            if (i_last_h) begin
                                i_reg     <= '0;
                                state_reg <= ST_U2;
                            end else begin
                                i_reg <= i_reg + 1'b1;
                            end
                        end
                    endcase
                end
                ST_U2: begin
                    if (st_reg == 3'd0) begin
                        st_reg <= 3'd1;
                    end else begin
                        st_reg <= 3'd0;
                        if (j_last) begin
                            j_reg     <= '0;
                            i_reg     <= '0;
                            state_reg <= ST_U1;
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                ST_U1: begin
                    if (st_reg == 3'd0) begin
                        st_reg <= 3'd1;
                    end else begin
                        st_reg <= 3'd0;
                        if (j_last) begin
                            j_reg <= '0;
                            if (i_last_h) begin
                                i_reg     <= '0;
                                state_reg <= ST_U0;
                            end else begin
                                i_reg <= i_reg + 1'b1;
                            end
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                ST_U0: begin
                    if (st_reg == 3'd0 && bit_set) begin
                        st_reg <= 3'd1;
                    end else begin
                        // step along the row, or drop to the next input once its row is done or it is clear
                        st_reg <= 3'd0;
                        if (st_reg == 3'd1 && !j_last) begin
                            j_reg <= j_reg + 1'b1;
                        end else begin
                            j_reg <= '0;
                            if (i_last_in) begin
                                i_reg     <= '0;
                                state_reg <= ST_FIN;
                            end else begin
                                i_reg <= i_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_pred_reg   <= pred_reg;
                        m_err_reg    <= err_reg;
                        m_wout_reg   <= wout_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `MLPBP_ASSERT_IMP(a_result_from_fin, $rose(m_tvalid_reg), $past(state_reg == ST_FIN), "result raised outside FIN")
    `MLPBP_ASSERT_NXT(a_busy_after_accept, s_acc, !s_tready, "ready held after accept")
    `MLPBP_ASSERT_IMP(a_write_in_range, ram_we, int'(ram_waddr) < NW, "weight write out of range")
    `MLPBP_ASSERT_IMP(a_update_only_train, ram_we && (state_reg != ST_IDLE), kind_reg == mlpbp_pkg::KIND_TRAIN, "weight update outside training")

endmodule

`default_nettype wire

### test/mlp_backprop_train_step_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mlp_backprop_train_step_tb
// Streams load, read, train and infer requests into the perceptron block with
// random gaps on both sides. A local fixed-point network predicts every result
// and each result is checked field by field as it arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_backprop_train_step_tb;

    localparam int NIN = 32;
    localparam int NH  = 4;
    localparam int N0  = NIN * NH;
    localparam int N1  = NH * NH;
    localparam int NW  = N0 + N1 + NH;
    localparam longint CYCLE_LIMIT = 8_000_000;

    typedef struct packed {
        mlpbp_pkg::kind_t kind;
        logic [31:0]      sample_bits;
        logic             target;
        logic [7:0]       weight_index;
        logic [23:0]      weight_value;
    } request_t;

    typedef struct packed {
        logic [15:0] prediction;
        logic [17:0] output_error;
        logic [23:0] weight_out;
    } answer_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [mlpbp_pkg::S_TDATA_W-1:0] s_tdata;
    logic [mlpbp_pkg::S_TUSER_W-1:0] s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [mlpbp_pkg::M_TDATA_W-1:0] m_tdata;

    mlp_backprop_train_step u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    request_t pending_q[$];
    answer_t  expected_q[$];
    longint   net_weights[NW];
    longint   sigmoid_lut[256];
    int       error_count = 0;
    longint   cycle_count = 0;
    bit       stim_done = 0;
    bit       hold_rx = 0;
    int       rx_hold_cycles = 0;
    int       tx_gap = 0;
    int       rx_gap = 0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // floor shift, matching truncation toward minus infinity
    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_bits(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic longint activate(longint q16);
        longint k;
        k = fshift(q16, 12) + 128;
        if (k < 0) k = 0;
        if (k > 255) k = 255;
        return sigmoid_lut[k];
    endfunction

    function automatic longint slope(longint a);
        return (a * (65536 - a)) >>> 16;
    endfunction

    task automatic fill_sigmoid_lut();
        longint unsigned p;
        longint unsigned den;
        longint unsigned pos[129];
        p = 64'd1 << 32;
        for (int k = 0; k <= 128; k++) begin
            den = (64'd1 << 32) + p;
            pos[k] = ((64'd1 << 48) + den / 2) / den;
            // 64-bit product would overflow; split the multiply
            p = ((p >> 16) * 64'd4034748382) + (((p & 64'hFFFF) * 64'd4034748382
                + (64'd1 << 31)) >> 16);
            p = p >> 16;
        end
        for (int k = 0; k < 256; k++)
            sigmoid_lut[k] = k >= 128 ? pos[k - 128] : 65536 - pos[128 - k];
    endtask

    function automatic answer_t run_network(request_t r);
        answer_t a;
        longint l1[NH], l2[NH], d1[NH], d2[NH];
        longint l3, d3, acc, err, wsig;
        a = '0;
        wsig = longint'($signed(r.weight_value));
        if (r.kind == mlpbp_pkg::KIND_LOAD) begin
            if (r.weight_index < NW) net_weights[r.weight_index] = clamp_bits(wsig, 24);
        end else if (r.kind == mlpbp_pkg::KIND_READ) begin
            if (r.weight_index < NW) a.weight_out = 24'(net_weights[r.weight_index]);
        end else begin
            for (int j = 0; j < NH; j++) begin
                acc = 0;
                for (int i = 0; i < NIN; i++)
                    if (r.sample_bits[i]) acc += net_weights[i * NH + j];
                l1[j] = activate(acc);
            end
            for (int j = 0; j < NH; j++) begin
                acc = 0;
                for (int i = 0; i < NH; i++) acc += l1[i] * net_weights[N0 + i * NH + j];
                l2[j] = activate(fshift(acc, 16));
            end
            acc = 0;
            for (int j = 0; j < NH; j++) acc += l2[j] * net_weights[N0 + N1 + j];
            l3 = activate(fshift(acc, 16));
            a.prediction = 16'(l3);
            if (r.kind == mlpbp_pkg::KIND_TRAIN) begin
                err = (r.target ? 65536 : 0) - l3;
                a.output_error = 18'(err);
                d3 = fshift(err * slope(l3), 16);
                for (int j = 0; j < NH; j++)
                    d2[j] = fshift(fshift(net_weights[N0 + N1 + j] * d3, 16) * slope(l2[j]), 16);
                for (int i = 0; i < NH; i++) begin
                    acc = 0;
                    for (int j = 0; j < NH; j++) acc += net_weights[N0 + i * NH + j] * d2[j];
                    d1[i] = fshift(fshift(acc, 16) * slope(l1[i]), 16);
                end
                for (int j = 0; j < NH; j++)
                    net_weights[N0 + N1 + j] = clamp_bits(net_weights[N0 + N1 + j]
                        + fshift(l2[j] * d3, 16), 24);
                for (int i = 0; i < NH; i++)
                    for (int j = 0; j < NH; j++)
                        net_weights[N0 + i * NH + j] = clamp_bits(net_weights[N0 + i * NH + j]
                            + fshift(l1[i] * d2[j], 16), 24);
                for (int i = 0; i < NIN; i++)
                    if (r.sample_bits[i])
                        for (int j = 0; j < NH; j++)
                            net_weights[i * NH + j] = clamp_bits(net_weights[i * NH + j]
                                + d1[j], 24);
            end
        end
        return a;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic request_t make_req(mlpbp_pkg::kind_t k, logic [31:0] bits,
                                          logic tgt, logic [7:0] idx, logic [23:0] val);
        request_t r;
        r.kind = k;
        r.sample_bits = bits;
        r.target = tgt;
        r.weight_index = idx;
        r.weight_value = val;
        return r;
    endfunction

    function automatic logic [23:0] rand_weight();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 24'h7FFFFF;
        if (roll == 1) return 24'h800000;
        if (roll < 6) return 24'($signed($urandom_range(0, 131072)) - 65536);
        return 24'($urandom);
    endfunction

    // stimulus: directed corners, then a random mix of loads, reads and inferences, mostly training
    initial begin
        mlpbp_pkg::kind_t k;
        pending_q.push_back(make_req(mlpbp_pkg::KIND_INFER, 32'h0, 1'b0, 8'd0, 24'h0));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_TRAIN, 32'hFFFFFFFF, 1'b1, 8'd0,
                                     24'h0));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_LOAD, 32'hFFFFFFFF, 1'b1, 8'd0,
                                     24'h7FFFFF));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_LOAD, 32'h0, 1'b0, 8'd147, 24'h800000));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_LOAD, 32'h0, 1'b0, 8'd255, 24'h123456));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_READ, 32'h0, 1'b0, 8'd0, 24'hFFFFFF));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_READ, 32'h0, 1'b0, 8'd147, 24'h0));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_READ, 32'h0, 1'b0, 8'd148, 24'h0));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_READ, 32'h0, 1'b0, 8'd255, 24'h0));
        for (int i = 0; i < NH; i++)
            pending_q.push_back(make_req(mlpbp_pkg::KIND_LOAD, 32'h0, 1'b0, 8'(i),
                                         24'h7FFFFF));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_INFER, 32'h0000000F, 1'b0, 8'd0,
                                     24'h0));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_TRAIN, 32'h00000001, 1'b0, 8'd0,
                                     24'h0));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_TRAIN, 32'h80000000, 1'b1, 8'd0,
                                     24'h0));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_LOAD, 32'h0, 1'b0, 8'd144, 24'h800000));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_INFER, 32'hFFFFFFFF, 1'b1, 8'd0,
                                     24'h0));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_TRAIN, 32'hFFFFFFFF, 1'b0, 8'd0,
                                     24'h0));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_READ, 32'h0, 1'b0, 8'd144, 24'h0));
        pending_q.push_back(make_req(mlpbp_pkg::KIND_READ, 32'h0, 1'b0, 8'd3, 24'h0));
        for (int n = 0; n < 1200; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: k = mlpbp_pkg::KIND_LOAD;
                3:       k = mlpbp_pkg::KIND_READ;
                4:       k = mlpbp_pkg::KIND_INFER;
                default: k = mlpbp_pkg::KIND_TRAIN;
            endcase
            pending_q.push_back(make_req(k,
                $urandom_range(0, 3) == 0 ? $urandom : ($urandom & $urandom & $urandom),
                1'($urandom), $urandom_range(0, 7) == 0 ? 8'($urandom) :
                8'($urandom_range(0, NW - 1)), rand_weight()));
        end
    end

    initial begin
        fill_sigmoid_lut();
        for (int i = 0; i < NW; i++) net_weights[i] = 0;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver: one request on offer at a time, with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_gap   <= 0;
        end else if (s_tvalid && !s_tready) begin
            // hold the request until it is taken
        end else begin
            if (s_tvalid) begin
                expected_q.push_back(run_network(pending_q.pop_front()));
            end
            // pause until drained once, midway through
            if (tx_gap > 0 || (pending_q.size() == 600 && expected_q.size() > 0
                               && s_tvalid == 1'b0) || pending_q.size() == 0) begin
                s_tvalid <= 1'b0;
                if (tx_gap > 0) tx_gap <= tx_gap - 1;
                if (pending_q.size() == 0) stim_done <= 1'b1;
            end else if (s_tvalid && pending_q.size() == 600) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_q[0].kind;
                s_tdata  <= {7'd0, pending_q[0].weight_value, pending_q[0].weight_index,
                             pending_q[0].target, pending_q[0].sample_bits};
                tx_gap   <= pick_gap();
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
            rx_hold_cycles <= 0;
            hold_rx  <= 1'b0;
        end else begin
            if (!hold_rx && pending_q.size() == 1000) begin
                hold_rx <= 1'b1;
                rx_hold_cycles <= 3000;
            end
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles <= rx_hold_cycles - 1;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready) rx_gap <= pick_gap();
            end
        end
    end

    // checker
    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.prediction   = m_tdata[15:0];
            got.output_error = m_tdata[33:16];
            got.weight_out   = m_tdata[57:34];
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: %h", m_tdata);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                if (got.prediction !== want.prediction) begin
                    $error("prediction expected %h got %h", want.prediction, got.prediction);
                    error_count++;
                end
                if (got.output_error !== want.output_error) begin
                    $error("output_error expected %h got %h", want.output_error,
                           got.output_error);
                    error_count++;
                end
                if (got.weight_out !== want.weight_out) begin
                    $error("weight_out expected %h got %h", want.weight_out, got.weight_out);
                    error_count++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (expected_q.size() != 0 || s_tvalid) @(posedge aclk);
        repeat (800) @(posedge aclk);
        if (expected_q.size() == 0 && error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

`default_nettype wire
